[rtl/double_ended_queue_assert.svh]
// Assertion macros for the double-ended queue.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// checked only out of reset
`define DQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
// Used by dq_cell and double_ended_queue; no dependencies.
package dq_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int MAX_EMIT    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int DATA_W      = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DUMP       = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_ELEM  = 2'd3;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT_IN,
		CELL_WRITE,
		CELL_SHIFT_OUT,
		CELL_ROTATE
	} cell_op_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		cell_op_t            op;
		logic [IDX_W-1:0]    pos;
		logic [DATA_W-1:0]   value;
	} cell_cmd_t;

endpackage

[rtl/dq_cell.sv]
// One storage cell of the deque chain.
// Depends on dq_pkg for the command struct and widths.
module dq_cell (
	input  logic                      clk,
	input  logic [dq_pkg::IDX_W-1:0]  idx,
	input  dq_pkg::cell_cmd_t         cmd,
	input  logic [dq_pkg::DATA_W-1:0] left,
	input  logic [dq_pkg::DATA_W-1:0] right,
	output logic [dq_pkg::DATA_W-1:0] data
);

	logic [dq_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			dq_pkg::CELL_SHIFT_IN: begin
				data_q <= left;
			end
			dq_pkg::CELL_WRITE: begin
				if (idx == cmd.pos) begin
					data_q <= cmd.value;
				end
			end
			dq_pkg::CELL_SHIFT_OUT: begin
				data_q <= right;
			end
			dq_pkg::CELL_ROTATE: begin
				// tail of the occupied run takes the head
				if (idx == cmd.pos) begin
					data_q <= cmd.value;
				end else begin
					data_q <= right;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

[rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit values held in a chain of cells.
// Depends on dq_pkg, dq_cell and double_ended_queue_assert.svh.
//
// channel  dir  tdata                  tuser         tlast
// s_*      in   [31:0] value           [2:0] opcode  -
// m_*      out  [31:0] element         [1:0] status  last
//
// Push and pop: cell 0 is the front; a front push or pop shifts the chain as a whole.
// Dump of n elements: once started, the occupied run rotates through cell 0, one
// element per step, back to its original order.
// Reset clears the fill count and the output stage; cell contents are not reset.
// A stalled m_tready holds the output register and stops new items and dump steps.
module double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [2:0]  s_tuser,  // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] element
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic        m_tlast
);

	logic [dq_pkg::CNT_W-1:0]  count_q;
	logic [dq_pkg::CNT_W-1:0]  steps_q;
	logic [dq_pkg::CNT_W-1:0]  emit_q;
	logic                      busy_q;
	logic                      out_valid_q;
	logic [1:0]                out_status_q;
	logic [dq_pkg::DATA_W-1:0] out_elem_q;
	logic                      out_last_q;

	logic                      out_free;
	logic                      in_acc;
	logic                      step;
	logic                      full;
	logic                      empty;
	logic                      full_push;
	logic                      empty_pop;
	logic                      dump_go;
	logic [dq_pkg::CNT_W-1:0]  cnt_dec;
	dq_pkg::cell_cmd_t         cmd;
	logic [dq_pkg::DATA_W-1:0] cell_data [dq_pkg::DEPTH];

	assign full     = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign cnt_dec  = count_q - dq_pkg::CNT_W'(1);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !busy_q && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign step     = busy_q && ((emit_q == '0) || out_free);

	assign full_push = in_acc && full &&
	                   ((s_tuser == dq_pkg::OP_PUSH_FRONT) || (s_tuser == dq_pkg::OP_PUSH_BACK));
	assign empty_pop = in_acc && empty &&
	                   ((s_tuser == dq_pkg::OP_POP_FRONT) || (s_tuser == dq_pkg::OP_POP_BACK));
	assign dump_go   = in_acc && !empty && (s_tuser == dq_pkg::OP_DUMP);

	always_comb begin
		cmd.op    = dq_pkg::CELL_HOLD;
		cmd.pos   = count_q[dq_pkg::IDX_W-1:0];
		cmd.value = s_tdata;
		if (step) begin
			cmd.op    = dq_pkg::CELL_ROTATE;
			cmd.pos   = cnt_dec[dq_pkg::IDX_W-1:0];
			cmd.value = cell_data[0];
		end else if (in_acc) begin
			case (s_tuser)
				dq_pkg::OP_PUSH_FRONT: begin
					if (!full) begin
						cmd.op = dq_pkg::CELL_SHIFT_IN;
					end
				end
				dq_pkg::OP_PUSH_BACK: begin
					if (!full) begin
						cmd.op = dq_pkg::CELL_WRITE;
					end
				end
				dq_pkg::OP_POP_FRONT: begin
					if (!empty) begin
						cmd.op = dq_pkg::CELL_SHIFT_OUT;
					end
				end
				default: begin
					cmd.op = dq_pkg::CELL_HOLD;
				end
			endcase
		end
	end

	for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
		logic [dq_pkg::DATA_W-1:0] left_d;
		logic [dq_pkg::DATA_W-1:0] right_d;
		if (g == 0) begin : g_head
			assign left_d = cmd.value;
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end
		if (g == dq_pkg::DEPTH - 1) begin : g_tail
			assign right_d = cmd.value;
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end
		dq_cell u_cell (
			.clk   (clk),
			.idx   (dq_pkg::IDX_W'(g)),
			.cmd   (cmd),
			.left  (left_d),
			.right (right_d),
			.data  (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			steps_q      <= '0;
			emit_q       <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= dq_pkg::ST_DONE;
			out_elem_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				steps_q <= steps_q - dq_pkg::CNT_W'(1);
				if (steps_q == dq_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
				if (emit_q != '0) begin
					emit_q       <= emit_q - dq_pkg::CNT_W'(1);
					out_valid_q  <= 1'b1;
					out_status_q <= dq_pkg::ST_ELEM;
					out_elem_q   <= cell_data[0];
					out_last_q   <= (emit_q == dq_pkg::CNT_W'(1));
				end
			end else if (in_acc) begin
				case (s_tuser)
					dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
						out_valid_q  <= 1'b1;
						out_status_q <= full ? dq_pkg::ST_FULL : dq_pkg::ST_DONE;
						out_elem_q   <= '0;
						out_last_q   <= 1'b1;
						if (!full) begin
							count_q <= count_q + dq_pkg::CNT_W'(1);
						end
					end
					dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
						out_valid_q  <= 1'b1;
						out_status_q <= empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_DONE;
						out_elem_q   <= '0;
						out_last_q   <= 1'b1;
						if (!empty) begin
							count_q <= cnt_dec;
						end
					end
					dq_pkg::OP_DUMP: begin
						if (!empty) begin
							busy_q  <= 1'b1;
							steps_q <= count_q;
							emit_q  <= (count_q > dq_pkg::CNT_W'(dq_pkg::MAX_EMIT)) ?
							           dq_pkg::CNT_W'(dq_pkg::MAX_EMIT) : count_q;
						end
					end
					default: begin
						out_last_q <= out_last_q;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_elem_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`include "double_ended_queue_assert.svh"

	`DQ_ASSERT_ALWAYS(a_no_accept_busy, busy_q |-> !s_tready, "item accepted during dump")
	`DQ_ASSERT(a_full_hold, full_push |=> $stable(count_q), "push into full store changed count")
	`DQ_ASSERT(a_empty_pop, empty_pop |=> m_tvalid && m_tuser == dq_pkg::ST_EMPTY, "empty pop unflagged")
	`DQ_ASSERT(a_dump_start, dump_go |=> busy_q && steps_q == $past(count_q), "dump did not start")

endmodule
